@@ design/tlhl_pkg.sv @@
// Shared types and constants for the tree LCA (heavy-light) block.
package tlhl_pkg;

    localparam int MAX_NODES_DEF = 1024;
    localparam int MAX_EDGES_DEF = 2048;
    localparam int NODE_W        = 10;
    localparam int DEPTH_W       = 10;
    localparam int ALU_W         = 18;

    localparam logic [1:0] OP_ADD_EDGE = 2'd0;
    localparam logic [1:0] OP_BUILD    = 2'd1;
    localparam logic [1:0] OP_QUERY    = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } in_item_t;

    typedef struct packed {
        logic [NODE_W-1:0] ancestor;
        logic              status;
    } out_item_t;

    typedef enum logic [1:0] {
        ALU_NOP,
        ALU_ADD,
        ALU_GT
    } alu_op_t;

    typedef struct packed {
        alu_op_t          op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0] value;
        logic             flag;
    } alu_rsp_t;

endpackage

@@ design/tree_lca_heavy_light_top.sv @@
// Tree LCA top: edge store, sizing and chain walks, chain-climbing query sequencer.
// One transaction at a time; in_stall stays high from acceptance until the result
// is loaded into the output register, which may still be waiting while the next
// item is taken. An edge add ends early when the store is full; a query climbs one
// chain per pass; a build clears the node tables other than the edge-list heads,
// then runs the sizing walk over the edge entries and nodes, then the chain walk.
// Each step waits on one registered RAM read, which sets the pace; a result held
// by out_stall delays the return to idle by the length of that stall.
// After reset a clearing pass over every node table entry runs before the first item.
module tree_lca_heavy_light_top #(
    parameter int MAX_NODES = tlhl_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES = tlhl_pkg::MAX_EDGES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  tlhl_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output tlhl_pkg::out_item_t out_data
);

    localparam int NW  = $clog2(MAX_NODES);
    localparam int EW  = $clog2(MAX_EDGES);
    localparam int SW  = $clog2(MAX_NODES + 1);
    localparam int SPW = NW + 1;
    localparam int DW  = tlhl_pkg::DEPTH_W;
    localparam int FW  = tlhl_pkg::NODE_W;
    localparam int AW  = tlhl_pkg::ALU_W;
    localparam int KW  = NW + EW;

    typedef enum logic [5:0] {
        S_RCLR, S_IDLE, S_DONE,
        S_A0, S_A1, S_A2, S_A3,
        S_BCLR, S_BROOT, S_BROOT2,
        S_ZLOOP, S_ZE1, S_ZE2, S_ZE3, S_ZP1, S_ZP2, S_ZP3,
        S_CINIT, S_C0, S_C1, S_C2, S_C3, S_C4, S_C5,
        S_Q0, S_Q1, S_Q2, S_Q3, S_Q4, S_Q5, S_Q6, S_Q7, S_Q8,
        S_QF1, S_QF2
    } state_t;

    state_t            state_reg;
    logic [NW-1:0]     cnt_reg;
    logic [SPW-1:0]    sp_reg;
    logic [NW-1:0]     cur_v_reg;
    logic [EW-1:0]     cur_e_reg;
    logic [NW-1:0]     a_reg;
    logic [NW-1:0]     b_reg;
    logic [NW-1:0]     t_reg;
    logic [NW-1:0]     child_reg;
    logic [SW-1:0]     szv_reg;
    logic [NW-1:0]     hv_reg;
    logic [NW-1:0]     ctv_reg;
    logic [NW-1:0]     tu_reg;
    logic [NW-1:0]     tv_reg;
    logic [DW-1:0]     du_reg;
    logic              flag_reg;
    logic [AW-1:0]     sum_reg;
    logic [EW-1:0]     ec_reg;
    logic [FW-1:0]     anc_reg;
    logic              status_reg;
    logic              out_valid_reg;
    tlhl_pkg::out_item_t out_data_reg;

    tlhl_pkg::alu_req_t alu_req;
    tlhl_pkg::alu_rsp_t alu_rsp;

    logic          tgt_we, nxt_we, head_we, par_we, siz_we, hvy_we, dep_we, ctp_we, stk_we;
    logic [EW-1:0] tgt_wa, tgt_ra, nxt_wa, nxt_ra;
    logic [NW-1:0] tgt_wd, tgt_rd;
    logic [EW-1:0] nxt_wd, nxt_rd;
    logic [NW-1:0] head_wa, head_ra;
    logic [EW-1:0] head_wd, head_rd;
    logic [NW-1:0] par_wa, par_ra, par_wd, par_rd;
    logic [NW-1:0] siz_wa, siz_ra;
    logic [SW-1:0] siz_wd, siz_rd;
    logic [NW-1:0] hvy_wa, hvy_ra, hvy_wd, hvy_rd;
    logic [NW-1:0] dep_wa, dep_ra;
    logic [DW-1:0] dep_wd, dep_rd;
    logic [NW-1:0] ctp_wa, ctp_ra, ctp_wd, ctp_rd;
    logic [NW-1:0] stk_wa, stk_ra;
    logic [KW-1:0] stk_wd, stk_rd;

    logic [NW-1:0] stk_node;
    logic [EW-1:0] stk_edge;
    logic          a_ok, b_ok;
    logic [EW-1:0] slot_lo;

    assign stk_node = stk_rd[KW-1:EW];
    assign stk_edge = stk_rd[EW-1:0];
    assign a_ok     = (in_data.node_a != '0) && (32'(in_data.node_a) < MAX_NODES);
    assign b_ok     = (in_data.node_b != '0) && (32'(in_data.node_b) < MAX_NODES);
    assign slot_lo  = ec_reg + EW'(1);

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    tlhl_alu u_alu (.req(alu_req), .rsp(alu_rsp));

    tlhl_ram #(.WIDTH(NW), .DEPTH(MAX_EDGES)) u_tgt (.clk, .we(tgt_we), .waddr(tgt_wa),
        .wdata(tgt_wd), .raddr(tgt_ra), .rdata(tgt_rd));
    tlhl_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_nxt (.clk, .we(nxt_we), .waddr(nxt_wa),
        .wdata(nxt_wd), .raddr(nxt_ra), .rdata(nxt_rd));
    tlhl_ram #(.WIDTH(EW), .DEPTH(MAX_NODES)) u_head (.clk, .we(head_we), .waddr(head_wa),
        .wdata(head_wd), .raddr(head_ra), .rdata(head_rd));
    tlhl_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_par (.clk, .we(par_we), .waddr(par_wa),
        .wdata(par_wd), .raddr(par_ra), .rdata(par_rd));
    tlhl_ram #(.WIDTH(SW), .DEPTH(MAX_NODES)) u_siz (.clk, .we(siz_we), .waddr(siz_wa),
        .wdata(siz_wd), .raddr(siz_ra), .rdata(siz_rd));
    tlhl_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_hvy (.clk, .we(hvy_we), .waddr(hvy_wa),
        .wdata(hvy_wd), .raddr(hvy_ra), .rdata(hvy_rd));
    tlhl_ram #(.WIDTH(DW), .DEPTH(MAX_NODES)) u_dep (.clk, .we(dep_we), .waddr(dep_wa),
        .wdata(dep_wd), .raddr(dep_ra), .rdata(dep_rd));
    tlhl_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_ctp (.clk, .we(ctp_we), .waddr(ctp_wa),
        .wdata(ctp_wd), .raddr(ctp_ra), .rdata(ctp_rd));
    tlhl_ram #(.WIDTH(KW), .DEPTH(MAX_NODES)) u_stk (.clk, .we(stk_we), .waddr(stk_wa),
        .wdata(stk_wd), .raddr(stk_ra), .rdata(stk_rd));

    // memory ports and shared ALU, steered by the current step
    always_comb
    begin
        tgt_we = 1'b0; tgt_wa = '0; tgt_wd = '0; tgt_ra = '0;
        nxt_we = 1'b0; nxt_wa = '0; nxt_wd = '0; nxt_ra = '0;
        head_we = 1'b0; head_wa = '0; head_wd = '0; head_ra = '0;
        par_we = 1'b0; par_wa = '0; par_wd = '0; par_ra = '0;
        siz_we = 1'b0; siz_wa = '0; siz_wd = '0; siz_ra = '0;
        hvy_we = 1'b0; hvy_wa = '0; hvy_wd = '0; hvy_ra = '0;
        dep_we = 1'b0; dep_wa = '0; dep_wd = '0; dep_ra = '0;
        ctp_we = 1'b0; ctp_wa = '0; ctp_wd = '0; ctp_ra = '0;
        stk_we = 1'b0; stk_wa = '0; stk_wd = '0; stk_ra = '0;
        alu_req = '0;
        unique case (state_reg)
            S_RCLR, S_BCLR:
            begin
                head_we = (state_reg == S_RCLR); head_wa = cnt_reg;
                par_we = 1'b1; par_wa = cnt_reg;
                siz_we = 1'b1; siz_wa = cnt_reg;
                hvy_we = 1'b1; hvy_wa = cnt_reg;
                dep_we = 1'b1; dep_wa = cnt_reg;
                ctp_we = 1'b1; ctp_wa = cnt_reg;
            end
            S_A0:
            begin
                head_ra = a_reg;
                alu_req = '{op: tlhl_pkg::ALU_ADD, a: AW'(ec_reg), b: AW'(2)};
            end
            S_A1:
            begin
                alu_req = '{op: tlhl_pkg::ALU_GT, a: sum_reg, b: AW'(MAX_EDGES - 1)};
                if (!alu_rsp.flag)
                begin
                    tgt_we = 1'b1; tgt_wa = slot_lo; tgt_wd = b_reg;
                    nxt_we = 1'b1; nxt_wa = slot_lo; nxt_wd = head_rd;
                    head_we = 1'b1; head_wa = a_reg; head_wd = slot_lo;
                end
            end
            S_A2:
            begin
                head_ra = b_reg;
            end
            S_A3:
            begin
                tgt_we = 1'b1; tgt_wa = EW'(sum_reg); tgt_wd = a_reg;
                nxt_we = 1'b1; nxt_wa = EW'(sum_reg); nxt_wd = head_rd;
                head_we = 1'b1; head_wa = b_reg; head_wd = EW'(sum_reg);
            end
            S_BROOT:
            begin
                siz_we = 1'b1; siz_wa = a_reg; siz_wd = SW'(1);
                head_ra = a_reg;
            end
            S_ZLOOP:
            begin
                if (cur_e_reg == '0)
                begin
                    stk_ra = NW'(sp_reg - SPW'(2));
                    siz_ra = cur_v_reg;
                end
                else
                begin
                    tgt_ra = cur_e_reg;
                    nxt_ra = cur_e_reg;
                end
            end
            S_ZE1:
            begin
                siz_ra = tgt_rd;
                dep_ra = cur_v_reg;
            end
            S_ZE2:
            begin
                alu_req = '{op: tlhl_pkg::ALU_ADD, a: AW'(dep_rd), b: AW'(1)};
                if (siz_rd == '0 && sp_reg != SPW'(MAX_NODES))
                begin
                    par_we = 1'b1; par_wa = t_reg; par_wd = cur_v_reg;
                    dep_we = 1'b1; dep_wa = t_reg; dep_wd = DW'(alu_rsp.value);
                    siz_we = 1'b1; siz_wa = t_reg; siz_wd = SW'(1);
                    stk_we = 1'b1; stk_wa = NW'(sp_reg - SPW'(1));
                    stk_wd = {cur_v_reg, cur_e_reg};
                    head_ra = t_reg;
                end
            end
            S_ZP1:
            begin
                siz_ra = stk_node;
                hvy_ra = stk_node;
            end
            S_ZP2:
            begin
                alu_req = '{op: tlhl_pkg::ALU_ADD, a: AW'(siz_rd), b: AW'(szv_reg)};
                siz_we = 1'b1; siz_wa = cur_v_reg; siz_wd = SW'(alu_rsp.value);
                siz_ra = hvy_rd;
            end
            S_ZP3:
            begin
                alu_req = '{op: tlhl_pkg::ALU_GT, a: AW'(szv_reg), b: AW'(siz_rd)};
                hvy_we = alu_rsp.flag; hvy_wa = cur_v_reg; hvy_wd = child_reg;
            end
            S_CINIT:
            begin
                ctp_we = 1'b1; ctp_wa = a_reg; ctp_wd = a_reg;
                stk_we = 1'b1; stk_wa = '0; stk_wd = {a_reg, EW'(0)};
            end
            S_C0:
            begin
                stk_ra = NW'(sp_reg - SPW'(1));
            end
            S_C1:
            begin
                head_ra = stk_node;
                hvy_ra  = stk_node;
                ctp_ra  = stk_node;
            end
            S_C3:
            begin
                tgt_ra = cur_e_reg;
                nxt_ra = cur_e_reg;
            end
            S_C4:
            begin
                par_ra = tgt_rd;
                ctp_ra = tgt_rd;
            end
            S_C5:
            begin
                if (t_reg != a_reg && par_rd == cur_v_reg && ctp_rd == '0)
                begin
                    ctp_we = 1'b1; ctp_wa = t_reg;
                    ctp_wd = (t_reg == hv_reg) ? ctv_reg : t_reg;
                    stk_we = (sp_reg < SPW'(MAX_NODES));
                    stk_wa = NW'(sp_reg); stk_wd = {t_reg, EW'(0)};
                end
            end
            S_Q0:
            begin
                siz_ra = a_reg;
            end
            S_Q1:
            begin
                siz_ra = b_reg;
            end
            S_Q3:
            begin
                ctp_ra = a_reg;
            end
            S_Q4:
            begin
                ctp_ra = b_reg;
            end
            S_Q5:
            begin
                dep_ra = (tu_reg == ctp_rd) ? a_reg : tu_reg;
            end
            S_Q6:
            begin
                dep_ra = tv_reg;
            end
            S_Q7:
            begin
                alu_req = '{op: tlhl_pkg::ALU_GT, a: AW'(du_reg), b: AW'(dep_rd)};
                par_ra = alu_rsp.flag ? tu_reg : tv_reg;
            end
            S_QF1:
            begin
                dep_ra = b_reg;
            end
            S_QF2:
            begin
                alu_req = '{op: tlhl_pkg::ALU_GT, a: AW'(dep_rd), b: AW'(du_reg)};
            end
            default:
            begin
                alu_req = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RCLR;
            cnt_reg       <= '0;
            sp_reg        <= '0;
            ec_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_RCLR, S_BCLR:
                begin
                    if (cnt_reg == NW'(MAX_NODES - 1))
                    begin
                        cnt_reg <= '0;
                        if (state_reg == S_RCLR)
                            state_reg <= S_IDLE;
                        else if (a_reg != '0)
                            state_reg <= S_BROOT;
                        else
                            state_reg <= S_DONE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + NW'(1);
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        anc_reg    <= '0;
                        status_reg <= 1'b0;
                        b_reg      <= NW'(in_data.node_b);
                        // out-of-range root behaves like no root
                        if (in_data.opcode == tlhl_pkg::OP_BUILD && !a_ok)
                            a_reg <= '0;
                        else
                            a_reg <= NW'(in_data.node_a);
                        unique case (in_data.opcode)
                            tlhl_pkg::OP_ADD_EDGE:
                                state_reg <= (a_ok && b_ok) ? S_A0 : S_DONE;
                            tlhl_pkg::OP_BUILD:
                                state_reg <= S_BCLR;
                            tlhl_pkg::OP_QUERY:
                                state_reg <= (a_ok && b_ok) ? S_Q0 : S_DONE;
                            default:
                                state_reg <= S_DONE;
                        endcase
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg         <= 1'b1;
                        out_data_reg.ancestor <= anc_reg;
                        out_data_reg.status   <= status_reg;
                        state_reg             <= S_IDLE;
                    end
                end
                S_A0:
                begin
                    sum_reg   <= alu_rsp.value;
                    state_reg <= S_A1;
                end
                S_A1:
                begin
                    if (alu_rsp.flag)
                    begin
                        status_reg <= 1'b1;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_A2;
                    end
                end
                S_A2:
                begin
                    state_reg <= S_A3;
                end
                S_A3:
                begin
                    ec_reg    <= EW'(sum_reg);
                    state_reg <= S_DONE;
                end
                S_BROOT:
                begin
                    state_reg <= S_BROOT2;
                end
                S_BROOT2:
                begin
                    cur_v_reg <= a_reg;
                    cur_e_reg <= head_rd;
                    sp_reg    <= SPW'(1);
                    state_reg <= S_ZLOOP;
                end
                S_ZLOOP:
                begin
                    if (cur_e_reg != '0)
                        state_reg <= S_ZE1;
                    else if (sp_reg == SPW'(1))
                        state_reg <= S_CINIT;
                    else
                        state_reg <= S_ZP1;
                end
                S_ZE1:
                begin
                    cur_e_reg <= nxt_rd;
                    t_reg     <= tgt_rd;
                    state_reg <= S_ZE2;
                end
                S_ZE2:
                begin
                    if (siz_rd == '0 && sp_reg != SPW'(MAX_NODES))
                        state_reg <= S_ZE3;
                    else
                        state_reg <= S_ZLOOP;
                end
                S_ZE3:
                begin
                    cur_v_reg <= t_reg;
                    cur_e_reg <= head_rd;
                    sp_reg    <= sp_reg + SPW'(1);
                    state_reg <= S_ZLOOP;
                end
                S_ZP1:
                begin
                    // finished child folds into its parent, parent becomes top
                    child_reg <= cur_v_reg;
                    szv_reg   <= siz_rd;
                    cur_v_reg <= stk_node;
                    cur_e_reg <= stk_edge;
                    sp_reg    <= sp_reg - SPW'(1);
                    state_reg <= S_ZP2;
                end
                S_ZP2:
                begin
                    state_reg <= S_ZP3;
                end
                S_ZP3:
                begin
                    state_reg <= S_ZLOOP;
                end
                S_CINIT:
                begin
                    sp_reg    <= SPW'(1);
                    state_reg <= S_C0;
                end
                S_C0:
                begin
                    if (sp_reg == '0)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        sp_reg    <= sp_reg - SPW'(1);
                        state_reg <= S_C1;
                    end
                end
                S_C1:
                begin
                    cur_v_reg <= stk_node;
                    state_reg <= S_C2;
                end
                S_C2:
                begin
                    cur_e_reg <= head_rd;
                    hv_reg    <= hvy_rd;
                    ctv_reg   <= ctp_rd;
                    state_reg <= S_C3;
                end
                S_C3:
                begin
                    state_reg <= (cur_e_reg == '0) ? S_C0 : S_C4;
                end
                S_C4:
                begin
                    t_reg     <= tgt_rd;
                    cur_e_reg <= nxt_rd;
                    state_reg <= S_C5;
                end
                S_C5:
                begin
                    if (t_reg != a_reg && par_rd == cur_v_reg && ctp_rd == '0 &&
                        sp_reg < SPW'(MAX_NODES))
                    begin
                        sp_reg <= sp_reg + SPW'(1);
                    end
                    state_reg <= S_C3;
                end
                S_Q0:
                begin
                    state_reg <= S_Q1;
                end
                S_Q1:
                begin
                    state_reg <= (siz_rd == '0) ? S_DONE : S_Q2;
                end
                S_Q2:
                begin
                    state_reg <= (siz_rd == '0) ? S_DONE : S_Q3;
                end
                S_Q3:
                begin
                    state_reg <= S_Q4;
                end
                S_Q4:
                begin
                    tu_reg    <= ctp_rd;
                    state_reg <= S_Q5;
                end
                S_Q5:
                begin
                    tv_reg    <= ctp_rd;
                    state_reg <= (tu_reg == ctp_rd) ? S_QF1 : S_Q6;
                end
                S_Q6:
                begin
                    du_reg    <= dep_rd;
                    state_reg <= S_Q7;
                end
                S_Q7:
                begin
                    flag_reg  <= alu_rsp.flag;
                    state_reg <= S_Q8;
                end
                S_Q8:
                begin
                    if (flag_reg)
                        a_reg <= par_rd;
                    else
                        b_reg <= par_rd;
                    state_reg <= (par_rd == '0) ? S_DONE : S_Q3;
                end
                S_QF1:
                begin
                    du_reg    <= dep_rd;
                    state_reg <= S_QF2;
                end
                S_QF2:
                begin
                    anc_reg   <= FW'(alu_rsp.flag ? a_reg : b_reg);
                    state_reg <= S_DONE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ design/tlhl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tlhl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/tlhl_alu.sv @@
// Shared adder / magnitude comparator used by the add and compare steps of the sequencer.
module tlhl_alu (
    input  tlhl_pkg::alu_req_t req,
    output tlhl_pkg::alu_rsp_t rsp
);

    always_comb
    begin
        rsp = '0;
        unique case (req.op)
            tlhl_pkg::ALU_ADD: rsp.value = req.a + req.b;
            tlhl_pkg::ALU_GT:  rsp.flag  = (req.a > req.b);
            default:           rsp = '0;
        endcase
    end

endmodule

@@ design/tlhl_checker.sv @@
// Port-level checks for the tree LCA block, bound to the top level.
module tlhl_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input tlhl_pkg::in_item_t  in_data,
    input logic                out_valid,
    input logic                out_stall,
    input tlhl_pkg::out_item_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("stalled result changed");

    // every accepted transaction leaves idle, so the block is busy right after
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken on consecutive cycles");

    a_status_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.status && out_data.ancestor != '0))
        else $error("drop flag with nonzero ancestor");

endmodule

bind tree_lca_heavy_light_top tlhl_checker u_tlhl_checker (.*);
